>>> design/bfoc_pkg.sv
`default_nettype none

package bfoc_pkg;

  // Field widths
  localparam int unsigned RawW  = 24;
  localparam int unsigned CalW  = 16;
  localparam int unsigned TempW = 18;
  localparam int unsigned PresW = 23;

  // Internal widths
  localparam int unsigned DtW   = RawW + 1;          // D2 - C5*256
  localparam int unsigned ProdW = DtW + CalW + 1;    // dT * Cn
  localparam int unsigned OffW  = 37;                // C2*2^17 + dT*C4/2^6
  localparam int unsigned SensW = 36;                // C1*2^16 + dT*C3/2^7
  localparam int unsigned LoW   = 18;                // low slice of SENS
  localparam int unsigned HiW   = SensW - LoW;       // signed high slice of SENS
  localparam int unsigned PpLoW = RawW + LoW;
  localparam int unsigned PpHiW = RawW + 1 + HiW;
  localparam int unsigned FullW = RawW + 1 + SensW;  // D1 * SENS
  localparam int unsigned ScW   = FullW - 21;        // D1*SENS / 2^21
  localparam int unsigned DiffW = ScW + 1;
  localparam int unsigned PfW   = DiffW - 15;        // pressure before clamp

  localparam logic [TempW+1:0] TempBase = 20'd2000;

  // Calibration register index codes
  typedef enum logic [2:0] {
    IdxPresSens = 3'd0,
    IdxPresOff  = 3'd1,
    IdxSensTc   = 3'd2,
    IdxOffTc    = 3'd3,
    IdxTempRef  = 3'd4,
    IdxTempTc   = 3'd5
  } cal_idx_e;

  // Calibration words C1..C6
  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

  // Beat passed from the compensation front end to the pressure back end
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic [RawW-1:0]         d1;
  } comp_t;

endpackage

`default_nettype wire

>>> design/bfoc_cal_regs.sv
`default_nettype none

module bfoc_cal_regs import bfoc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [CalW-1:0] cfg_wdata_i,
  output cal_t                 cal_o
);

  cal_t cal_q;

  // Write decode; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        IdxPresSens: cal_q.c1 <= cfg_wdata_i;
        IdxPresOff:  cal_q.c2 <= cfg_wdata_i;
        IdxSensTc:   cal_q.c3 <= cfg_wdata_i;
        IdxOffTc:    cal_q.c4 <= cfg_wdata_i;
        IdxTempRef:  cal_q.c5 <= cfg_wdata_i;
        IdxTempTc:   cal_q.c6 <= cfg_wdata_i;
        default:     cal_q    <= cal_q;
      endcase
    end
  end

  assign cal_o = cal_q;

endmodule

`default_nettype wire

>>> design/bfoc_comp.sv
`default_nettype none

module bfoc_comp import bfoc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [RawW-1:0] raw_pressure_i,
  input  wire logic [RawW-1:0] raw_temperature_i,
  input  wire cal_t            cal_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output comp_t                out_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic signed [DtW-1:0]   dt_q;
  logic [RawW-1:0]         d1_s1_q, d1_s2_q;
  logic signed [ProdW-1:0] p6_q, p4_q, p3_q;
  comp_t                   out_q;

  logic signed [DtW-1:0]   dt_d;
  logic [TempW+1:0]        temp_full;
  logic signed [TempW-1:0] temp_d;
  logic signed [OffW-1:0]  off_d;
  logic signed [SensW-1:0] sens_d;

  // Stage enables: a stage loads when empty or when its beat moves on
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: dT = D2 - C5*256
  assign dt_d = {1'b0, raw_temperature_i} - {1'b0, cal_i.c5, 8'b0};

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_pressure_i;
    end
  end

  // Stage 2: the three dT products
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      p6_q    <= dt_q * $signed({1'b0, cal_i.c6});
      p4_q    <= dt_q * $signed({1'b0, cal_i.c4});
      p3_q    <= dt_q * $signed({1'b0, cal_i.c3});
      d1_s2_q <= d1_s1_q;
    end
  end

  // Stage 3: TEMP with saturation, OFF and SENS (floor shifts)
  assign temp_full = {p6_q[ProdW-1], p6_q[ProdW-1:23]} + TempBase;

  always_comb begin
    if (temp_full[TempW+1:TempW-1] == 3'b000 || temp_full[TempW+1:TempW-1] == 3'b111) begin
      temp_d = temp_full[TempW-1:0];
    end else if (temp_full[TempW+1]) begin
      temp_d = {1'b1, {(TempW-1){1'b0}}};
    end else begin
      temp_d = {1'b0, {(TempW-1){1'b1}}};
    end
  end

  assign off_d  = {4'b0, cal_i.c2, 17'b0} + {p4_q[ProdW-1], p4_q[ProdW-1:6]};
  assign sens_d = {4'b0, cal_i.c1, 16'b0} + {p3_q[ProdW-1], p3_q[ProdW-1:7]};

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out_q.temp <= temp_d;
      out_q.off  <= off_d;
      out_q.sens <= sens_d;
      out_q.d1   <= d1_s2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> design/bfoc_pres.sv
`default_nettype none

module bfoc_pres import bfoc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire comp_t             in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [TempW-1:0] temp_o,
  output logic signed [PresW-1:0] pres_o
);

  logic v4_q, v5_q, v6_q;
  logic en4, en5, en6;

  logic [PpLoW-1:0]         pp_lo_q;
  logic signed [PpHiW-1:0]  pp_hi_q;
  logic signed [OffW-1:0]   off_s4_q, off_s5_q;
  logic signed [TempW-1:0]  temp_s4_q, temp_s5_q, temp_q;
  logic signed [ScW-1:0]    scaled_q;
  logic signed [PresW-1:0]  pres_q;

  logic [FullW-1:0]         full;
  logic [DiffW-1:0]         diff;
  logic [PfW-1:0]           pres_full;
  logic signed [PresW-1:0]  pres_d;

  assign en6        = !v6_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Stage 4: D1*SENS as two partial products (unsigned low, signed high slice)
  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      pp_lo_q   <= in_i.d1 * in_i.sens[LoW-1:0];
      pp_hi_q   <= $signed({1'b0, in_i.d1}) * $signed(in_i.sens[SensW-1:LoW]);
      off_s4_q  <= in_i.off;
      temp_s4_q <= in_i.temp;
    end
  end

  // Stage 5: combine partials, floor divide by 2^21
  assign full = {pp_hi_q, {LoW{1'b0}}} + {{(FullW-PpLoW){1'b0}}, pp_lo_q};

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      scaled_q  <= full[FullW-1:21];
      off_s5_q  <= off_s4_q;
      temp_s5_q <= temp_s4_q;
    end
  end

  // Stage 6: subtract OFF, floor divide by 2^15, saturate
  assign diff      = {scaled_q[ScW-1], scaled_q} - {{(DiffW-OffW){off_s5_q[OffW-1]}}, off_s5_q};
  assign pres_full = diff[DiffW-1:15];

  always_comb begin
    if (pres_full[PfW-1:PresW-1] == '0 || pres_full[PfW-1:PresW-1] == '1) begin
      pres_d = pres_full[PresW-1:0];
    end else if (pres_full[PfW-1]) begin
      pres_d = {1'b1, {(PresW-1){1'b0}}};
    end else begin
      pres_d = {1'b0, {(PresW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      pres_q <= pres_d;
      temp_q <= temp_s5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign temp_o      = temp_q;
  assign pres_o      = pres_q;

endmodule

`default_nettype wire

>>> design/barometer_first_order_compensation_unit.sv
// Barometer first-order compensation.
// Input channel: in_valid_i / in_stall_o carry one beat of raw pressure (D1)
// and raw temperature (D2), both 24-bit unsigned conversions.
// Output channel: out_valid_o / out_stall_i carry one beat of compensated
// temperature (0.01 degC, 18-bit signed, saturated) and pressure (Pa).
// Calibration words C1..C6 are written through cfg_we_i / cfg_index_i /
// cfg_wdata_i, indexes 0..5; other indexes are ignored. Write them only
// while no beats are in flight.
// Throughput: one beat per cycle while out_stall_i is low, set by the
// six-stage pipeline (dT, three dT products, TEMP/OFF/SENS, split
// D1*SENS product, recombine, subtract).
// When out_stall_i is high the pipe fills up behind the held result; once
// every stage is full in_stall_o rises. No beat is dropped or repeated.
// Reset clears all calibration words to zero and empties the pipeline.
`default_nettype none

module barometer_first_order_compensation_unit import bfoc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [RawW-1:0]   raw_pressure_i,
  input  wire logic [RawW-1:0]   raw_temperature_i,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [CalW-1:0]   cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [TempW-1:0] temperature_centi_o,
  output logic signed [PresW-1:0] pressure_pa_o
);

  cal_t  cal;
  comp_t comp;
  logic  comp_valid, comp_ready, in_ready;

  bfoc_cal_regs u_cal_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  // Stages 1-3: dT, products, TEMP / OFF / SENS
  bfoc_comp u_comp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .cal_i             (cal),
    .out_valid_o       (comp_valid),
    .out_ready_i       (comp_ready),
    .out_o             (comp)
  );

  // Stages 4-6: pressure
  bfoc_pres u_pres (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (comp_valid),
    .in_ready_o  (comp_ready),
    .in_i        (comp),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .temp_o      (temperature_centi_o),
    .pres_o      (pressure_pa_o)
  );

  assign in_stall_o = !in_ready;

endmodule

`default_nettype wire

>>> design/bfoc_check.sv
`default_nettype none

module bfoc_check import bfoc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [TempW-1:0]  temperature_centi_o,
  input wire logic [PresW-1:0]  pressure_pa_o
);

  // A held result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat withdrawn while stalled");

  // A held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(temperature_centi_o) && $stable(pressure_pa_o))
    else $error("result payload changed while stalled");

  // The pipe only pushes back when the result side is stalled
  a_stall_source: assert property (@(posedge clk_i)
    in_stall_o |-> out_stall_i)
    else $error("input stalled with result side free");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty in reset");

endmodule

bind barometer_first_order_compensation_unit bfoc_check u_bfoc_check (.*);

`default_nettype wire
